### sv/mam_pkg.sv
// mam_pkg: shared types and constants for the multi-alarm matcher.
// Holds the alarm entry layout, the scan token carried along the cell chain
// and the repeat mode codes. No dependencies.
package mam_pkg;

    localparam int ALARM_COUNT = 8;

    localparam int INDEX_W  = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int REPEAT_W = 2;
    localparam int DAY_W    = 3;

    localparam logic [REPEAT_W-1:0] REP_SINGLE  = 2'd0;
    localparam logic [REPEAT_W-1:0] REP_DAILY   = 2'd1;
    localparam logic [REPEAT_W-1:0] REP_WORKDAY = 2'd2;
    localparam logic [REPEAT_W-1:0] REP_WEEKEND = 2'd3;

    localparam logic [DAY_W-1:0] DAY_SUNDAY   = 3'd0;
    localparam logic [DAY_W-1:0] DAY_MONDAY   = 3'd1;
    localparam logic [DAY_W-1:0] DAY_FRIDAY   = 3'd5;
    localparam logic [DAY_W-1:0] DAY_SATURDAY = 3'd6;

    typedef struct packed {
        logic                enable;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [REPEAT_W-1:0] repeat_mode;
        logic                motor;
        logic                buzzer;
    } entry_t;

    // Scan token: one tick walking the chain, one cell per cycle.
    typedef struct packed {
        logic                valid;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                workday;
        logic                weekend;
        logic                found;
        logic                kill;
        logic [INDEX_W-1:0]  idx;
        logic                motor;
        logic                buzzer;
    } token_t;

endpackage

### sv/mam_cell.sv
// mam_cell: one alarm entry of the matcher chain.
// Holds the entry, checks the passing scan token against it and registers
// the updated token for the next cell. Depends on mam_pkg.
module mam_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mam_pkg::entry_t     wr_entry,
    input  logic [mam_pkg::INDEX_W-1:0] cell_idx,
    input  mam_pkg::token_t     tok_in,
    output mam_pkg::token_t     tok_out
);

    mam_pkg::entry_t entry_reg;
    mam_pkg::entry_t entry_next;
    mam_pkg::token_t tok_reg;
    mam_pkg::token_t tok_next;

    logic hit;
    logic day_ok;
    logic is_single;
    logic fire;
    logic clear;

    always_comb
    begin
        is_single = (entry_reg.repeat_mode == mam_pkg::REP_SINGLE);
        hit = tok_in.valid && entry_reg.enable
            && (entry_reg.hour == tok_in.hour)
            && (entry_reg.minute == tok_in.minute);
        case (entry_reg.repeat_mode)
            mam_pkg::REP_SINGLE:  day_ok = 1'b1;
            mam_pkg::REP_DAILY:   day_ok = 1'b1;
            mam_pkg::REP_WORKDAY: day_ok = tok_in.workday;
            mam_pkg::REP_WEEKEND: day_ok = tok_in.weekend;
            default:              day_ok = 1'b0;
        endcase
        fire  = hit && day_ok && !tok_in.found;
        // drop the enable of a firing single entry and of later matching singles
        clear = hit && is_single && (fire || tok_in.kill);

        tok_next = tok_in;
        if (fire)
        begin
            tok_next.found  = 1'b1;
            tok_next.kill   = is_single;
            tok_next.idx    = cell_idx;
            tok_next.motor  = entry_reg.motor;
            tok_next.buzzer = entry_reg.buzzer;
        end

        entry_next = entry_reg;
        if (wr_en)
        begin
            entry_next = wr_entry;
        end
        else if (clear)
        begin
            entry_next.enable = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### sv/multi_alarm_matcher.sv
// multi_alarm_matcher: top level of the minute alarm matcher.
// Instantiates a chain of mam_cell entries; depends on mam_pkg.
// Timing: a write beat's result goes straight into the output register; a tick
// beat's result passes through every cell register and then the output register.
// Throughput: one write per cycle while results are taken; a tick holds off new
// beats until its scan token has walked the cell chain, one cell per cycle.
// Reset (rst_n low, asynchronous): all entries disabled and zero, last fired
// index zero, no result pending.
module multi_alarm_matcher (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [mam_pkg::INDEX_W-1:0]       entry_index,
    input  logic                              entry_enable,
    input  logic [mam_pkg::HOUR_W-1:0]        entry_hour,
    input  logic [mam_pkg::MINUTE_W-1:0]      entry_minute,
    input  logic [mam_pkg::REPEAT_W-1:0]      entry_repeat,
    input  logic                              entry_motor,
    input  logic                              entry_buzzer,
    input  logic [mam_pkg::HOUR_W-1:0]        now_hour,
    input  logic [mam_pkg::MINUTE_W-1:0]      now_minute,
    input  logic [mam_pkg::DAY_W-1:0]         now_weekday,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              fired,
    output logic [mam_pkg::INDEX_W-1:0]       alarm_index,
    output logic                              motor_on,
    output logic                              buzzer_on
);

    localparam int N = mam_pkg::ALARM_COUNT;

    // Handshake and request decode
    logic accept;
    logic wr_accept;
    logic tick_accept;

    // Control state: busy while a tick token is in the chain
    logic busy_reg;
    logic busy_next;
    logic [mam_pkg::INDEX_W-1:0] last_fired_reg;
    logic [mam_pkg::INDEX_W-1:0] last_fired_next;

    // Output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        fired_reg;
    logic                        fired_next;
    logic [mam_pkg::INDEX_W-1:0] index_reg;
    logic [mam_pkg::INDEX_W-1:0] index_next;
    logic                        motor_reg;
    logic                        motor_next;
    logic                        buzzer_reg;
    logic                        buzzer_next;

    // Chain: tok[k] feeds cell k, tok[N] leaves the last cell
    mam_pkg::token_t tok [0:N];
    mam_pkg::entry_t wr_entry;
    logic [N-1:0]    wr_en;

    // Accept a beat only when no scan runs and the result slot is free or
    // draining this cycle; one item is in flight at a time.
    assign in_ready    = !busy_reg && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign wr_accept   = accept && req_type;
    assign tick_accept = accept && !req_type;

    always_comb
    begin
        wr_entry.enable      = entry_enable;
        wr_entry.hour        = entry_hour;
        wr_entry.minute      = entry_minute;
        wr_entry.repeat_mode = entry_repeat;
        wr_entry.motor       = entry_motor;
        wr_entry.buzzer      = entry_buzzer;
    end

    // Inject the tick token at the head of the chain. Weekday seven is
    // neither a workday nor a weekend day.
    always_comb
    begin
        tok[0].valid   = tick_accept;
        tok[0].hour    = now_hour;
        tok[0].minute  = now_minute;
        tok[0].workday = (now_weekday >= mam_pkg::DAY_MONDAY)
                      && (now_weekday <= mam_pkg::DAY_FRIDAY);
        tok[0].weekend = (now_weekday == mam_pkg::DAY_SUNDAY)
                      || (now_weekday == mam_pkg::DAY_SATURDAY);
        tok[0].found   = 1'b0;
        tok[0].kill    = 1'b0;
        tok[0].idx     = '0;
        tok[0].motor   = 1'b0;
        tok[0].buzzer  = 1'b0;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            // Every index of the chain is reachable by a 3-bit write index.
            assign wr_en[k] = wr_accept && (32'(entry_index) == 32'(k));

            mam_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_en    (wr_en[k]),
                .wr_entry (wr_entry),
                .cell_idx (mam_pkg::INDEX_W'(k)),
                .tok_in   (tok[k]),
                .tok_out  (tok[k+1])
            );
        end
    endgenerate

    // Result and control update
    always_comb
    begin
        busy_next       = busy_reg;
        last_fired_next = last_fired_reg;
        out_valid_next  = out_valid_reg;
        fired_next      = fired_reg;
        index_next      = index_reg;
        motor_next      = motor_reg;
        buzzer_next     = buzzer_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (tick_accept)
        begin
            busy_next = 1'b1;
        end

        if (wr_accept)
        begin
            // write beat: report no match and hold the last fired index
            out_valid_next = 1'b1;
            fired_next     = 1'b0;
            index_next     = last_fired_reg;
            motor_next     = 1'b0;
            buzzer_next    = 1'b0;
        end
        else if (tok[N].valid)
        begin
            // token has left the last cell: close the scan
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            fired_next     = tok[N].found;
            motor_next     = tok[N].motor;
            buzzer_next    = tok[N].buzzer;
            if (tok[N].found)
            begin
                last_fired_next = tok[N].idx;
                index_next      = tok[N].idx;
            end
            else
            begin
                index_next = last_fired_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            last_fired_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            last_fired_reg <= last_fired_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg  <= fired_next;
        index_reg  <= index_next;
        motor_reg  <= motor_next;
        buzzer_reg <= buzzer_next;
    end

    assign out_valid   = out_valid_reg;
    assign fired       = fired_reg;
    assign alarm_index = index_reg;
    assign motor_on    = motor_reg;
    assign buzzer_on   = buzzer_reg;

endmodule

### sv/mam_checker.sv
// mam_checker: port-level assertions for multi_alarm_matcher.
// Watches the top-level ports only and is attached by the bind below.
// Depends on mam_pkg for field widths.
module mam_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         req_type,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         fired,
    input  logic [mam_pkg::INDEX_W-1:0]  alarm_index,
    input  logic                         motor_on,
    input  logic                         buzzer_on
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired)
            && $stable(alarm_index) && $stable(motor_on) && $stable(buzzer_on))
        else $error("result beat changed while stalled");

    // a write beat answers in the next cycle with no match
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type |=> out_valid && !fired
            && !motor_on && !buzzer_on)
        else $error("write beat did not give a quiet result");

    // motor and buzzer requests only come with a fired alarm
    a_no_fire_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> !motor_on && !buzzer_on)
        else $error("actuator request without a fired alarm");

    // no new beat while an undelivered result blocks the slot
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result stalled");

    // a tick scan holds off the next beat
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !req_type |=> !in_ready)
        else $error("input ready during a tick scan");

endmodule

bind multi_alarm_matcher mam_checker u_mam_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fired       (fired),
    .alarm_index (alarm_index),
    .motor_on    (motor_on),
    .buzzer_on   (buzzer_on)
);

### tb/mam_checker.sv
// mam_scoreboard: request codes and the result checker for the multi-alarm matcher.
// Watches both channels, keeps its own alarm table and compares every result beat.
// Depends on mam_pkg.
package mam_tb_pkg;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

endpackage

module mam_scoreboard
    import mam_pkg::*;
    import mam_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic                entry_enable,
    input  logic [HOUR_W-1:0]   entry_hour,
    input  logic [MINUTE_W-1:0] entry_minute,
    input  logic [REPEAT_W-1:0] entry_repeat,
    input  logic                entry_motor,
    input  logic                entry_buzzer,
    input  logic [HOUR_W-1:0]   now_hour,
    input  logic [MINUTE_W-1:0] now_minute,
    input  logic [DAY_W-1:0]    now_weekday,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                fired,
    input  logic [INDEX_W-1:0]  alarm_index,
    input  logic                motor_on,
    input  logic                buzzer_on,

    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic               fired;
        logic [INDEX_W-1:0] idx;
        logic               motor;
        logic               buzzer;
    } alarm_result_t;

    entry_t             alarm_table [ALARM_COUNT];
    logic [INDEX_W-1:0] last_fired;
    alarm_result_t      expected_q [$];
    alarm_result_t      oldest;
    entry_t             new_entry;
    int                 errors_seen = 0;

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic time_hit(entry_t e, logic [HOUR_W-1:0] h,
                                      logic [MINUTE_W-1:0] m);
        return e.enable && (e.hour == h) && (e.minute == m);
    endfunction

    // Scan in index order; the first qualifying entry fires. A firing single
    // entry disarms itself and every later single entry set for the same time.
    function automatic alarm_result_t match_tick(logic [HOUR_W-1:0] h,
                                                 logic [MINUTE_W-1:0] m,
                                                 logic [DAY_W-1:0] wd);
        alarm_result_t res;
        logic          workday;
        logic          weekend;
        logic          allowed;
        res     = '0;
        workday = (wd >= DAY_MONDAY) && (wd <= DAY_FRIDAY);
        weekend = (wd == DAY_SUNDAY) || (wd == DAY_SATURDAY);
        for (int i = 0; i < ALARM_COUNT; i++)
        begin
            if (!res.fired && time_hit(alarm_table[i], h, m))
            begin
                case (alarm_table[i].repeat_mode)
                    REP_SINGLE, REP_DAILY: allowed = 1'b1;
                    REP_WORKDAY:           allowed = workday;
                    default:               allowed = weekend;
                endcase
                if (allowed)
                begin
                    res.fired  = 1'b1;
                    res.motor  = alarm_table[i].motor;
                    res.buzzer = alarm_table[i].buzzer;
                    last_fired = INDEX_W'(i);
                    if (alarm_table[i].repeat_mode == REP_SINGLE)
                    begin
                        for (int j = i; j < ALARM_COUNT; j++)
                        begin
                            if (time_hit(alarm_table[j], h, m)
                                && alarm_table[j].repeat_mode == REP_SINGLE)
                                alarm_table[j].enable = 1'b0;
                        end
                    end
                end
            end
        end
        res.idx = last_fired;
        return res;
    endfunction

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (alarm_table[i])
                alarm_table[i] = '0;
            last_fired = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // Retire the result beat first: it always belongs to an older request.
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    errors_seen++;
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    check_field("fired", oldest.fired, fired);
                    check_field("alarm_index", oldest.idx, alarm_index);
                    check_field("motor_on", oldest.motor, motor_on);
                    check_field("buzzer_on", oldest.buzzer, buzzer_on);
                end
            end
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_WRITE)
                begin
                    new_entry.enable      = entry_enable;
                    new_entry.hour        = entry_hour;
                    new_entry.minute      = entry_minute;
                    new_entry.repeat_mode = entry_repeat;
                    new_entry.motor       = entry_motor;
                    new_entry.buzzer      = entry_buzzer;
                    if (entry_index < ALARM_COUNT)
                        alarm_table[entry_index] = new_entry;
                    expected_q.push_back('{fired: 1'b0, idx: last_fired,
                                           motor: 1'b0, buzzer: 1'b0});
                end
                else
                    expected_q.push_back(match_tick(now_hour, now_minute, now_weekday));
            end
            pending    <= expected_q.size();
            fail_count <= errors_seen;
        end
    end

endmodule

### tb/tb_multi_alarm_matcher.sv
// tb_multi_alarm_matcher: stimulus and verdict for the multi-alarm matcher.
// Drives directed and random write and tick beats with random idling on both
// sides; depends on mam_pkg, mam_tb_pkg and mam_scoreboard.
module tb_multi_alarm_matcher;
    import mam_pkg::*;
    import mam_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_LEN    = 150;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = ALARM_COUNT + 8;
    localparam int TIME_LIMIT   = 4_000_000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;

    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                req_type     = REQ_TICK;
    logic [INDEX_W-1:0]  entry_index  = '0;
    logic                entry_enable = 1'b0;
    logic [HOUR_W-1:0]   entry_hour   = '0;
    logic [MINUTE_W-1:0] entry_minute = '0;
    logic [REPEAT_W-1:0] entry_repeat = REP_SINGLE;
    logic                entry_motor  = 1'b0;
    logic                entry_buzzer = 1'b0;
    logic [HOUR_W-1:0]   now_hour     = '0;
    logic [MINUTE_W-1:0] now_minute   = '0;
    logic [DAY_W-1:0]    now_weekday  = DAY_SUNDAY;

    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic                fired;
    logic [INDEX_W-1:0]  alarm_index;
    logic                motor_on;
    logic                buzzer_on;

    int                  fail_count;
    int                  pending;

    // When set, both sides run back to back with no idle cycles.
    logic                no_idle      = 1'b0;

    // A small pool of alarm times shared by writes and ticks, so that ticks
    // land on armed entries often and several entries share one time.
    logic [HOUR_W-1:0]   hot_hour   [4];
    logic [MINUTE_W-1:0] hot_minute [4];

    multi_alarm_matcher u_top (.*);

    mam_scoreboard u_checker (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial
    begin
        #TIME_LIMIT;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: draw a stall per beat, hold ready high until a beat moves.
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Present one request beat after a random gap and hold it until taken.
    // Valid drops only when a gap follows, so it is never lowered and raised
    // in the same step.
    task automatic send_request(input logic rq, input logic [INDEX_W-1:0] idx,
                                input logic en, input logic [HOUR_W-1:0] eh,
                                input logic [MINUTE_W-1:0] em,
                                input logic [REPEAT_W-1:0] rep,
                                input logic mot, input logic buz,
                                input logic [HOUR_W-1:0] nh,
                                input logic [MINUTE_W-1:0] nm,
                                input logic [DAY_W-1:0] wd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type     <= rq;
        entry_index  <= idx;
        entry_enable <= en;
        entry_hour   <= eh;
        entry_minute <= em;
        entry_repeat <= rep;
        entry_motor  <= mot;
        entry_buzzer <= buz;
        now_hour     <= nh;
        now_minute   <= nm;
        now_weekday  <= wd;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Write one entry; fill the unused tick fields with noise.
    task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic en,
                               input logic [HOUR_W-1:0] h,
                               input logic [MINUTE_W-1:0] m,
                               input logic [REPEAT_W-1:0] rep,
                               input logic mot, input logic buz);
        send_request(REQ_WRITE, idx, en, h, m, rep, mot, buz,
                     HOUR_W'($urandom), MINUTE_W'($urandom), DAY_W'($urandom));
    endtask

    // Send one minute tick; fill the unused entry fields with noise.
    task automatic tick_at(input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] m,
                           input logic [DAY_W-1:0] wd);
        send_request(REQ_TICK, INDEX_W'($urandom), 1'($urandom), HOUR_W'($urandom),
                     MINUTE_W'($urandom), REPEAT_W'($urandom), 1'($urandom),
                     1'($urandom), h, m, wd);
    endtask

    // Mostly a time from the pool; now and then any bit pattern at all,
    // out-of-range hours and minutes included.
    task automatic pick_time(output logic [HOUR_W-1:0] h, output logic [MINUTE_W-1:0] m);
        int slot;
        slot = $urandom_range(0, 3);
        h = ($urandom_range(0, 6) == 0) ? HOUR_W'($urandom) : hot_hour[slot];
        m = ($urandom_range(0, 6) == 0) ? MINUTE_W'($urandom) : hot_minute[slot];
    endtask

    initial
    begin
        logic [HOUR_W-1:0]   h;
        logic [MINUTE_W-1:0] m;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table after reset: nothing can fire.
        tick_at(5'd0, 6'd0, DAY_SUNDAY);

        // Two singles and a daily on one time, workday and weekend on another.
        write_entry(3'd0, 1'b1, 5'd6, 6'd30, REP_SINGLE, 1'b1, 1'b0);
        write_entry(3'd3, 1'b1, 5'd6, 6'd30, REP_SINGLE, 1'b0, 1'b1);
        write_entry(3'd5, 1'b1, 5'd6, 6'd30, REP_DAILY, 1'b1, 1'b1);
        write_entry(3'd7, 1'b1, 5'd23, 6'd59, REP_WORKDAY, 1'b1, 1'b1);
        write_entry(3'd6, 1'b1, 5'd23, 6'd59, REP_WEEKEND, 1'b0, 1'b1);

        // First single fires and disarms the later single; then the daily wins.
        tick_at(5'd6, 6'd30, 3'd2);
        tick_at(5'd6, 6'd30, 3'd2);

        // Weekend entry on Saturday, skipped midweek so the workday entry
        // fires, neither on weekday seven, weekend again on Sunday.
        tick_at(5'd23, 6'd59, DAY_SATURDAY);
        tick_at(5'd23, 6'd59, 3'd3);
        tick_at(5'd23, 6'd59, 3'd7);
        tick_at(5'd23, 6'd59, DAY_SUNDAY);

        // Out-of-range hour and minute match bit for bit.
        write_entry(3'd1, 1'b1, 5'd31, 6'd63, REP_DAILY, 1'b1, 1'b1);
        tick_at(5'd31, 6'd63, DAY_FRIDAY);

        // A disabled entry never fires; a single fires on weekday seven once.
        write_entry(3'd2, 1'b0, 5'd12, 6'd0, REP_DAILY, 1'b1, 1'b1);
        tick_at(5'd12, 6'd0, DAY_MONDAY);
        write_entry(3'd4, 1'b1, 5'd12, 6'd0, REP_SINGLE, 1'b0, 1'b0);
        tick_at(5'd12, 6'd0, 3'd7);
        tick_at(5'd12, 6'd0, 3'd7);

        // Workday bounds: Monday and Friday fire, Saturday does not.
        write_entry(3'd0, 1'b1, 5'd0, 6'd0, REP_WORKDAY, 1'b1, 1'b0);
        tick_at(5'd0, 6'd0, DAY_MONDAY);
        tick_at(5'd0, 6'd0, DAY_FRIDAY);
        tick_at(5'd0, 6'd0, DAY_SATURDAY);

        // Random part: roughly half writes, half ticks, drawn from a time pool
        // that is refreshed every phase. Each phase also picks whether both
        // sides idle or run flat out.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                no_idle = ($urandom_range(0, 2) == 0);
                for (int k = 0; k < 4; k++)
                begin
                    hot_hour[k]   = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom)
                                                                : HOUR_W'($urandom_range(0, 23));
                    hot_minute[k] = ($urandom_range(0, 9) == 0) ? MINUTE_W'($urandom)
                                                                : MINUTE_W'($urandom_range(0, 59));
                end
            end
            pick_time(h, m);
            if ($urandom_range(0, 1) == 0)
                write_entry(INDEX_W'($urandom), ($urandom_range(0, 4) != 0), h, m,
                            REPEAT_W'($urandom), 1'($urandom), 1'($urandom));
            else
                tick_at(h, m, DAY_W'($urandom));
        end

        // Drop valid, drain every outstanding result, then watch for strays.
        in_valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
